// ===== rtl/pixel_contrast_hsv_threshold_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel HSV threshold unit
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef PIXEL_CONTRAST_HSV_THRESHOLD_UNIT_MACROS_SVH
`define PIXEL_CONTRAST_HSV_THRESHOLD_UNIT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define HSVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another in the next cycle
`define HSVT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/hsvt_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV threshold package
// Widths, register indexes and reset values shared by the pipeline.
// ----------------------------------------------------------------------------
package hsvt_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned GainW  = 12;
  localparam int unsigned OffW   = 9;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SdW    = 20;
  localparam int unsigned HdW    = 17;
  localparam int unsigned HrawW  = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN     = 4'd0,
    REG_OFFSET   = 4'd1,
    REG_HUE_LOW  = 4'd2,
    REG_HUE_HIGH = 4'd3,
    REG_SAT_LOW  = 4'd4,
    REG_SAT_HIGH = 4'd5,
    REG_VAL_LOW  = 4'd6,
    REG_VAL_HIGH = 4'd7
  } cfg_reg_e;

  localparam logic [GainW-1:0] GainReset   = 12'd256;
  localparam logic [ChanW-1:0] HueHighReset = 8'd179;
  localparam logic [ChanW-1:0] HueWrap      = 8'd180;

  typedef struct packed {
    logic [ChanW-1:0] hue_low;
    logic [ChanW-1:0] hue_high;
    logic [ChanW-1:0] sat_low;
    logic [ChanW-1:0] sat_high;
    logic [ChanW-1:0] val_low;
    logic [ChanW-1:0] val_high;
  } bounds_t;

endpackage

// ===== rtl/hsvt_if.sv =====
// ----------------------------------------------------------------------------
// Pixel and HSV stream interfaces
// Valid/ready channels for the BGR input and the HSV result.
// ----------------------------------------------------------------------------
interface hsvt_pix_if import hsvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] blue_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] red_in;

  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface hsvt_hsv_if import hsvt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             in_range_mask;
  logic [ChanW-1:0] hue_out;
  logic [ChanW-1:0] sat_out;
  logic [ChanW-1:0] val_out;

  modport source (output valid, in_range_mask, hue_out, sat_out, val_out, input ready);
  modport sink   (input valid, in_range_mask, hue_out, sat_out, val_out, output ready);
endinterface

// ===== rtl/hsvt_adjust.sv =====
// ----------------------------------------------------------------------------
// Channel adjust
// Gain, offset, round half to even and clamp of one channel.
// ----------------------------------------------------------------------------
module hsvt_adjust import hsvt_pkg::*; (
  input  logic [GainW-1:0]       gain_i,
  input  logic signed [OffW-1:0] offset_i,
  input  logic [ChanW-1:0]       chan_i,
  output logic [ChanW-1:0]       chan_o
);

  logic [GainW+ChanW-1:0] prod;
  logic signed [21:0]     sum;
  logic [20:0]            biased;
  logic [12:0]            whole;
  logic                   inc;
  logic [13:0]            rnd;

  always_comb begin
    prod   = (GainW+ChanW)'(gain_i) * (GainW+ChanW)'(chan_i);
    sum    = $signed({2'b00, prod}) + $signed({{5{offset_i[OffW-1]}}, offset_i, 8'h00})
             + 22'sd65536;
    biased = sum[20:0];
    whole  = biased[20:8];
    inc    = (biased[7:0] > 8'd128) || ((biased[7:0] == 8'd128) && biased[8]);
    rnd    = {1'b0, whole} + {13'd0, inc};
    if (rnd < 14'd256) begin
      chan_o = '0;
    end else if (rnd > 14'd511) begin
      chan_o = '1;
    end else begin
      chan_o = rnd[7:0];
    end
  end

endmodule

// ===== rtl/hsvt_recip.sv =====
// ----------------------------------------------------------------------------
// Reciprocal tables
// Constant lookups for the saturation and hue scale factors.
// ----------------------------------------------------------------------------
module hsvt_recip import hsvt_pkg::*; (
  input  logic [ChanW-1:0] val_i,
  input  logic [ChanW-1:0] diff_i,
  output logic [SdW-1:0]   sd_o,
  output logic [HdW-1:0]   hd_o
);

  localparam int unsigned Entries = 1 << ChanW;

  logic [SdW-1:0] sd_tbl [Entries];
  logic [HdW-1:0] hd_tbl [Entries];

  for (genvar gi = 0; gi < Entries; gi++) begin : g_tbl
    localparam int unsigned SdVal = (gi == 0) ? 0 : (2 * 255 * 4096 + gi) / (2 * gi);
    localparam int unsigned HdVal = (gi == 0) ? 0 : (2 * 30 * 4096 + gi) / (2 * gi);
    assign sd_tbl[gi] = SdVal[SdW-1:0];
    assign hd_tbl[gi] = HdVal[HdW-1:0];
  end

  assign sd_o = sd_tbl[val_i];
  assign hd_o = hd_tbl[diff_i];

endmodule

// ===== rtl/pixel_contrast_hsv_threshold_unit.sv =====
// Throughput: one pixel per cycle while the output is not stalled; four
// register stages (adjust, max/min and table lookup, multiply, hue wrap and
// range test) advance together.
// Reset: clears all stage valid bits and loads the register reset values
// (unity gain, zero offset, full bounds); no clearing pass.
// ----------------------------------------------------------------------------
// Pixel contrast HSV threshold unit
// Contrast/brightness adjust, BGR to HSV conversion and range mask.
// ----------------------------------------------------------------------------
`include "pixel_contrast_hsv_threshold_unit_macros.svh"

module pixel_contrast_hsv_threshold_unit import hsvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  hsvt_pix_if.sink            pix_i,
  hsvt_hsv_if.source          hsv_o
);

  logic [GainW-1:0]       gain_q;
  logic signed [OffW-1:0] offset_q;
  bounds_t                bnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GainReset;
      offset_q      <= '0;
      bnd_q.hue_low <= '0;
      bnd_q.hue_high <= HueHighReset;
      bnd_q.sat_low <= '0;
      bnd_q.sat_high <= '1;
      bnd_q.val_low <= '0;
      bnd_q.val_high <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN:     gain_q         <= cfg_data_i[GainW-1:0];
        REG_OFFSET:   offset_q       <= cfg_data_i[OffW-1:0];
        REG_HUE_LOW:  bnd_q.hue_low  <= cfg_data_i[ChanW-1:0];
        REG_HUE_HIGH: bnd_q.hue_high <= cfg_data_i[ChanW-1:0];
        REG_SAT_LOW:  bnd_q.sat_low  <= cfg_data_i[ChanW-1:0];
        REG_SAT_HIGH: bnd_q.sat_high <= cfg_data_i[ChanW-1:0];
        REG_VAL_LOW:  bnd_q.val_low  <= cfg_data_i[ChanW-1:0];
        REG_VAL_HIGH: bnd_q.val_high <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en          = !v4_q || hsv_o.ready;
  assign pix_i.ready = en;
  assign hsv_o.valid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: adjust
  logic [ChanW-1:0] ab_d, ag_d, ar_d, ab_q, ag_q, ar_q;

  hsvt_adjust u_adj_b (.gain_i(gain_q), .offset_i(offset_q), .chan_i(pix_i.blue_in),
                       .chan_o(ab_d));
  hsvt_adjust u_adj_g (.gain_i(gain_q), .offset_i(offset_q), .chan_i(pix_i.green_in),
                       .chan_o(ag_d));
  hsvt_adjust u_adj_r (.gain_i(gain_q), .offset_i(offset_q), .chan_i(pix_i.red_in),
                       .chan_o(ar_d));

  // stage 2: max, min, raw hue, table lookup
  logic [ChanW-1:0]        mx, mn, diff;
  logic signed [HrawW-1:0] hraw;
  logic [SdW-1:0]          sd;
  logic [HdW-1:0]          hd;
  logic [ChanW-1:0]        v2_val_q, v2_diff_q;
  logic signed [HrawW-1:0] hraw_q;
  logic [SdW-1:0]          sd_q;
  logic [HdW-1:0]          hd_q;

  always_comb begin
    mx = ab_q;
    mn = ab_q;
    if (ag_q > mx) mx = ag_q;
    if (ar_q > mx) mx = ar_q;
    if (ag_q < mn) mn = ag_q;
    if (ar_q < mn) mn = ar_q;
    diff = mx - mn;
    if (mx == ar_q) begin
      hraw = $signed({4'd0, ag_q}) - $signed({4'd0, ab_q});
    end else if (mx == ag_q) begin
      hraw = $signed({4'd0, ab_q}) - $signed({4'd0, ar_q}) + $signed({3'd0, diff, 1'b0});
    end else begin
      hraw = $signed({4'd0, ar_q}) - $signed({4'd0, ag_q}) + $signed({2'd0, diff, 2'b00});
    end
  end

  hsvt_recip u_recip (.val_i(mx), .diff_i(diff), .sd_o(sd), .hd_o(hd));

  // stage 3: multiply
  logic [SdW+ChanW-1:0] sp_q;
  logic signed [29:0]   hp_q;
  logic [ChanW-1:0]     v3_val_q;

  // stage 4: hue wrap and range test
  logic [SdW+ChanW-1:0] ssum;
  logic signed [29:0]   hsum;
  logic signed [9:0]    hq, hw;
  logic [ChanW-1:0]     hue_d, sat_d;
  logic                 mask_d;

  always_comb begin
    ssum  = sp_q + (SdW+ChanW)'(2048);
    sat_d = ssum[19:12];
    hsum  = hp_q + 30'sd2048;
    hq    = hsum[21:12];
    if (hq < 10'sd0) begin
      hw = hq + 10'sd180;
    end else if (hq >= 10'sd180) begin
      hw = hq - 10'sd180;
    end else begin
      hw = hq;
    end
    hue_d  = hw[7:0];
    mask_d = (hue_d >= bnd_q.hue_low) && (hue_d <= bnd_q.hue_high) &&
             (sat_d >= bnd_q.sat_low) && (sat_d <= bnd_q.sat_high) &&
             (v3_val_q >= bnd_q.val_low) && (v3_val_q <= bnd_q.val_high);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_q      <= ab_d;
      ag_q      <= ag_d;
      ar_q      <= ar_d;
      v2_val_q  <= mx;
      v2_diff_q <= diff;
      hraw_q    <= hraw;
      sd_q      <= sd;
      hd_q      <= hd;
      sp_q      <= (SdW+ChanW)'(v2_diff_q) * (SdW+ChanW)'(sd_q);
      hp_q      <= 30'(hraw_q * $signed({1'b0, hd_q}));
      v3_val_q  <= v2_val_q;
      hsv_o.in_range_mask <= mask_d;
      hsv_o.hue_out       <= hue_d;
      hsv_o.sat_out       <= sat_d;
      hsv_o.val_out       <= v3_val_q;
    end
  end

  logic val_ok;

  assign val_ok = (hsv_o.val_out >= bnd_q.val_low) && (hsv_o.val_out <= bnd_q.val_high);

  `HSVT_ASSERT(a_hue_range, !hsv_o.valid || (hsv_o.hue_out < HueWrap), "hue out of range")
  `HSVT_ASSERT_NEXT(a_stage_adv, en && v3_q, hsv_o.valid, "stage valid lost")
  `HSVT_ASSERT(a_mask_val, !(hsv_o.valid && hsv_o.in_range_mask && $stable(bnd_q)) || val_ok, "mask set outside value bounds")

endmodule

// ===== tb/pixel_contrast_hsv_threshold_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Pixel contrast HSV threshold unit testbench
// Drives BGR pixel requests under random gaps and output stalls, predicts the
// adjusted HSV values and range mask in integer arithmetic, and compares each
// result in order across several register settings.
// ----------------------------------------------------------------------------
module pixel_contrast_hsv_threshold_unit_tb;
  import hsvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic       mask;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  hsvt_pix_if pix ();
  hsvt_hsv_if hsv ();

  pixel_contrast_hsv_threshold_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pix_i(pix.sink), .hsv_o(hsv.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned gain_q;
  int offset_q;
  int unsigned hue_lo, hue_hi, sat_lo, sat_hi, val_lo, val_hi;

  pixel_t pending_pixels[$];
  hsv_t expected_hsv[$];
  int mismatch_count = 0;
  bit stall_hold = 1'b0;
  int hold_cycles = 0;

  function automatic int adjust_chan(int c);
    int t, q, r;
    t = int'(gain_q) * c + offset_q * 256 + 65536;
    q = (t >>> 8) - 256;
    r = t & 255;
    if (r > 128 || (r == 128 && (q & 1))) q++;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q;
  endfunction

  function automatic hsv_t threshold_pixel(pixel_t p);
    hsv_t o;
    int b, g, r, v, mn, diff, s, hraw, hd, h;
    longint x;
    b = adjust_chan(p.blue);
    g = adjust_chan(p.green);
    r = adjust_chan(p.red);
    v = b; mn = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    diff = v - mn;
    s = 0;
    if (v > 0) s = (diff * ((2 * 255 * 4096 + v) / (2 * v)) + 2048) >> 12;
    if (v == r) hraw = g - b;
    else if (v == g) hraw = b - r + 2 * diff;
    else hraw = r - g + 4 * diff;
    hd = (diff > 0) ? (2 * 30 * 4096 + diff) / (2 * diff) : 0;
    x = longint'(hraw) * hd + 2048;
    if (x >= 0) h = int'(x >>> 12);
    else h = -int'((-x + 4095) >>> 12);
    if (h < 0) h += 180;
    if (h >= 180) h -= 180;
    o.mask = (h >= hue_lo && h <= hue_hi && s >= sat_lo && s <= sat_hi &&
              v >= val_lo && v <= val_hi);
    o.hue = h[7:0];
    o.sat = s[7:0];
    o.val = v[7:0];
    return o;
  endfunction

  task automatic queue_pixel(pixel_t p);
    pending_pixels = {pending_pixels, p};
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[CfgDataW-1:0];
    case (idx)
      REG_GAIN:     gain_q = data & 12'hFFF;
      REG_OFFSET:   offset_q = (data & 9'h100) ? int'(data & 9'h1FF) - 512 : int'(data & 9'h1FF);
      REG_HUE_LOW:  hue_lo = data & 8'hFF;
      REG_HUE_HIGH: hue_hi = data & 8'hFF;
      REG_SAT_LOW:  sat_lo = data & 8'hFF;
      REG_SAT_HIGH: sat_hi = data & 8'hFF;
      REG_VAL_LOW:  val_lo = data & 8'hFF;
      REG_VAL_HIGH: val_hi = data & 8'hFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while ((pending_pixels.size() != 0 || pix.valid || expected_hsv.size() != 0) &&
           n < 200000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int k;
    k = $urandom_range(0, 9);
    p = pixel_t'(24'($urandom));
    if (k == 0) p.green = p.blue;
    if (k == 1) begin p.green = p.blue; p.red = p.blue; end
    if (k == 2) p.red = p.green;
    if (k == 3) p.red = p.blue;
    return p;
  endfunction

  int gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.blue_in <= '0;
      pix.green_in <= '0;
      pix.red_in <= '0;
      gap <= 0;
    end else begin
      if (!pix.valid || pix.ready) begin
        if (pix.valid)
          expected_hsv = {expected_hsv,
                          threshold_pixel({pix.blue_in, pix.green_in, pix.red_in})};
        if (gap > 0 || pending_pixels.size() == 0) begin
          pix.valid <= 1'b0;
          if (gap > 0) gap <= gap - 1;
        end else begin
          pixel_t p;
          p = pending_pixels.pop_front();
          pix.valid <= 1'b1;
          pix.blue_in <= p.blue;
          pix.green_in <= p.green;
          pix.red_in <= p.red;
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2)) : 0;
        end
      end
    end
  end

  int rgap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsv.ready <= 1'b0;
      rgap <= 0;
    end else begin
      if (hsv.valid && hsv.ready) begin
        hsv_t got, want;
        got = {hsv.in_range_mask, hsv.hue_out, hsv.sat_out, hsv.val_out};
        if (expected_hsv.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_hsv.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected mask %0d h %0d s %0d v %0d, got mask %0d h %0d s %0d v %0d",
                       want.mask, want.hue, want.sat, want.val,
                       got.mask, got.hue, got.sat, got.val);
          end
        end
      end
      if (stall_hold) begin
        hsv.ready <= 1'b0;
      end else if (rgap > 0) begin
        hsv.ready <= 1'b0;
        rgap <= rgap - 1;
      end else begin
        hsv.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          rgap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      stall_hold <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      stall_hold <= 1'b0;
    end
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int phase, i;
    pixel_t p;
    gain_q = 256; offset_q = 0;
    hue_lo = 0; hue_hi = 179; sat_lo = 0; sat_hi = 255; val_lo = 0; val_hi = 255;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, gray pixels, each max channel, ties
    queue_pixel('{8'd0, 8'd0, 8'd0});
    queue_pixel('{8'd255, 8'd255, 8'd255});
    queue_pixel('{8'd77, 8'd77, 8'd77});
    queue_pixel('{8'd0, 8'd0, 8'd255});
    queue_pixel('{8'd0, 8'd255, 8'd0});
    queue_pixel('{8'd255, 8'd0, 8'd0});
    queue_pixel('{8'd10, 8'd200, 8'd200});
    queue_pixel('{8'd200, 8'd10, 8'd200});
    queue_pixel('{8'd200, 8'd200, 8'd10});
    queue_pixel('{8'd20, 8'd0, 8'd255});
    queue_pixel('{8'd0, 8'd20, 8'd255});
    queue_pixel('{8'd1, 8'd0, 8'd0});
    queue_pixel('{8'd85, 8'd170, 8'd255});
    queue_pixel('{8'd170, 8'd85, 8'd1});
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_GAIN, 4095); write_reg(REG_OFFSET, 9'h100); end
        1: begin write_reg(REG_GAIN, 0); write_reg(REG_OFFSET, 255); end
        2: begin
          write_reg(REG_GAIN, 384); write_reg(REG_OFFSET, 9'h1FF);
          write_reg(REG_HUE_LOW, 30); write_reg(REG_HUE_HIGH, 120);
          write_reg(REG_SAT_LOW, 50); write_reg(REG_SAT_HIGH, 200);
          write_reg(REG_VAL_LOW, 40); write_reg(REG_VAL_HIGH, 220);
        end
        3: begin
          write_reg(REG_GAIN, 129); write_reg(REG_OFFSET, 9'h101);
          write_reg(REG_HUE_LOW, 255); write_reg(REG_HUE_HIGH, 255);
        end
        4: begin
          write_reg(REG_GAIN, 256); write_reg(REG_OFFSET, 0);
          write_reg(REG_HUE_LOW, 100); write_reg(REG_HUE_HIGH, 20);
          write_reg(REG_SAT_LOW, 255); write_reg(REG_SAT_HIGH, 0);
          write_reg(REG_VAL_LOW, 255); write_reg(REG_VAL_HIGH, 0);
        end
        5: begin
          write_reg(REG_GAIN, $urandom_range(0, 4095));
          write_reg(REG_OFFSET, $urandom_range(0, 511));
          write_reg(REG_HUE_LOW, 0); write_reg(REG_HUE_HIGH, 179);
          write_reg(REG_SAT_LOW, 0); write_reg(REG_SAT_HIGH, 255);
          write_reg(REG_VAL_LOW, 0); write_reg(REG_VAL_HIGH, 255);
        end
        6: begin
          write_reg(REG_GAIN, $urandom_range(128, 640));
          write_reg(REG_OFFSET, $urandom_range(0, 511));
          write_reg(REG_HUE_LOW, $urandom_range(0, 90));
          write_reg(REG_HUE_HIGH, $urandom_range(90, 179));
          write_reg(REG_SAT_LOW, $urandom_range(0, 128));
          write_reg(REG_SAT_HIGH, $urandom_range(128, 255));
          write_reg(REG_VAL_LOW, $urandom_range(0, 128));
          write_reg(REG_VAL_HIGH, $urandom_range(128, 255));
        end
        default: begin
          write_reg(REG_GAIN, 256); write_reg(REG_OFFSET, 0);
          write_reg(REG_HUE_LOW, 0); write_reg(REG_HUE_HIGH, 179);
          write_reg(REG_SAT_LOW, 0); write_reg(REG_SAT_HIGH, 255);
          write_reg(REG_VAL_LOW, 0); write_reg(REG_VAL_HIGH, 255);
        end
      endcase
      for (i = 0; i < 190; i++) begin
        p = random_pixel();
        queue_pixel(p);
      end
      if (phase == 6) begin
        @(posedge clk_i);
        hold_cycles <= 300;
      end
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_hsv.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== pixel_contrast_hsv_threshold_unit.f =====
+incdir+rtl
rtl/hsvt_pkg.sv
rtl/hsvt_if.sv
rtl/hsvt_adjust.sv
rtl/hsvt_recip.sv
rtl/pixel_contrast_hsv_threshold_unit.sv
tb/pixel_contrast_hsv_threshold_unit_tb.sv
